### sv/ipal_pkg.sv
// ----------------------------------------------------------------------------
// ipal_pkg: shared types and constants of the ip allow-list lookup
// table size, derived widths, operation and status codes, sequencer states
// ----------------------------------------------------------------------------
package ipal_pkg;

   // entries per bank
   localparam int TABLE_DEPTH = 1024;

   // memory holds both banks
   localparam int MEM_DEPTH = 2 * TABLE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   // position or count within one bank, 0 .. TABLE_DEPTH
   localparam int POS_W     = $clog2(TABLE_DEPTH + 1);

   localparam int IP_W      = 32;
   localparam int PERM_W    = 2;
   localparam int ENTRY_W   = IP_W + PERM_W;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 11;

   // operation codes; the unused code behaves as a lookup
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
   localparam logic [OP_W-1:0] OP_COMMIT = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_DENIED    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALLOWED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_LOADED    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_COMMITTED = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_CMP,
      S_PROBE,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_RESP
   } state_type;

   // bank-local count to the 11-bit result field
   function automatic logic [COUNT_W-1:0] to_count(input logic [POS_W-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      return w[COUNT_W-1:0];
   endfunction

endpackage

### sv/ip_allowlist_lookup.sv
// ----------------------------------------------------------------------------
// ip_allowlist_lookup: double-buffered ipv4 allow-list with binary search
// sorted (descending) address table, shadow-bank loads, bank swap on commit
// ----------------------------------------------------------------------------
// One word is worked on at a time; req_stall is high from acceptance until the
// result is handed to the output register, which may still hold the previous
// result. All work goes through one single-port-read, single-port-write
// memory holding both banks, with registered read data, and one 32-bit
// compare. A lookup runs a binary search over the n active entries, each step
// a read and then a compare, followed by a probe of the insertion point. A
// load runs the same search in the shadow bank plus a read and a write for
// each entry shifted down to open its slot; a duplicate or a dropped load
// costs only the search. A commit swaps the banks without a search. There is
// no clearing pass after reset: only entries below a bank's count ever decide
// a result, and those were always written.
// ----------------------------------------------------------------------------
module ip_allowlist_lookup import ipal_pkg::*; (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [IP_W-1:0]     req_ip_address,
   input  logic [PERM_W-1:0]   req_entry_perm,
   input  logic [PERM_W-1:0]   req_access_type,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_entry_count
);

   // sequencer
   state_type state_ff, state_in;

   // bank bookkeeping
   logic             active_bank_ff;
   logic [POS_W-1:0] active_count_ff;
   logic [POS_W-1:0] shadow_count_ff;

   // captured word
   logic [IP_W-1:0]   key_ff;
   logic [PERM_W-1:0] perm_ff;
   logic [PERM_W-1:0] acc_ff;
   logic              is_load_ff;

   // search state: bank and count under search, bounds, probe position
   logic             bank_ff;
   logic [POS_W-1:0] cnt_ff;
   logic [POS_W-1:0] lo_ff;
   logic [POS_W-1:0] hi_ff;
   logic [POS_W-1:0] mid_ff;
   logic             pos_ok_ff;
   logic [POS_W-1:0] idx_ff;

   // pending result
   logic [STATUS_W-1:0] res_status_ff;
   logic [POS_W-1:0]    res_count_ff;

   // output register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_entry_count_ff;

   // table memory, both banks, {address, perm} per entry
   logic [ENTRY_W-1:0] bank_mem_ff [MEM_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // memory port controls
   logic [ADDR_W-1:0]  rd_idx;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_idx;
   logic [ENTRY_W-1:0] wr_data;

   logic             req_take;
   logic             out_free;
   logic [POS_W-1:0] mid;
   logic             found;
   logic             shadow_full;
   logic             shift_more;

   // bank base plus position
   function automatic logic [ADDR_W-1:0] mem_index(input logic bank,
                                                   input logic [POS_W-1:0] pos);
      logic [ADDR_W-1:0] base;
      base = bank ? ADDR_W'(TABLE_DEPTH) : '0;
      return base + ADDR_W'(pos);
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // midpoint of the half-open interval [lo, hi)
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   // entry at the insertion point carries the same address
   assign found       = pos_ok_ff && (rd_data_ff[ENTRY_W-1:PERM_W] == key_ff);
   assign shadow_full = (shadow_count_ff >= POS_W'(TABLE_DEPTH));
   assign shift_more  = (idx_ff > lo_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = (req_operation == OP_COMMIT) ? S_RESP : S_SEARCH;
            end
         end
         S_SEARCH: begin
            state_in = (lo_ff < hi_ff) ? S_CMP : S_PROBE;
         end
         S_CMP: begin
            state_in = S_SEARCH;
         end
         S_PROBE: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!is_load_ff || found || shadow_full) begin
               state_in = S_RESP;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            state_in = shift_more ? S_SHIFT_WR : S_RESP;
         end
         S_SHIFT_WR: begin
            state_in = S_SHIFT_RD;
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // memory port controls
   always_comb begin
      rd_idx  = '0;
      wr_en   = 1'b0;
      wr_idx  = '0;
      wr_data = '0;
      unique case (state_ff)
         S_SEARCH: begin
            rd_idx = mem_index(bank_ff, mid);
         end
         S_PROBE: begin
            rd_idx = mem_index(bank_ff, lo_ff);
         end
         S_DECIDE: begin
            // duplicate load: overwrite permission in place
            if (is_load_ff && found) begin
               wr_en   = 1'b1;
               wr_idx  = mem_index(bank_ff, lo_ff);
               wr_data = {key_ff, perm_ff};
            end
         end
         S_SHIFT_RD: begin
            if (shift_more) begin
               rd_idx = mem_index(bank_ff, idx_ff - POS_W'(1));
            end else begin
               // slot is open, drop the new entry in
               wr_en   = 1'b1;
               wr_idx  = mem_index(bank_ff, lo_ff);
               wr_data = {key_ff, perm_ff};
            end
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_idx  = mem_index(bank_ff, idx_ff);
            wr_data = rd_data_ff;
         end
         S_IDLE, S_CMP, S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // table memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_mem_ff[wr_idx] <= wr_data;
      end
      rd_data_ff <= bank_mem_ff[rd_idx];
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         active_bank_ff  <= 1'b1;
         active_count_ff <= '0;
         shadow_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         // output register fills from the pending result, drains when taken
         if (state_ff == S_RESP && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  key_ff     <= req_ip_address;
                  perm_ff    <= req_entry_perm;
                  acc_ff     <= req_access_type;
                  is_load_ff <= (req_operation == OP_LOAD);
                  lo_ff      <= '0;
                  if (req_operation == OP_COMMIT) begin
                     // swap banks, shadow becomes live, fresh empty shadow
                     active_bank_ff  <= ~active_bank_ff;
                     active_count_ff <= shadow_count_ff;
                     shadow_count_ff <= '0;
                     res_status_ff   <= STATUS_COMMITTED;
                     res_count_ff    <= shadow_count_ff;
                  end else if (req_operation == OP_LOAD) begin
                     bank_ff <= ~active_bank_ff;
                     cnt_ff  <= shadow_count_ff;
                     hi_ff   <= shadow_count_ff;
                  end else begin
                     bank_ff <= active_bank_ff;
                     cnt_ff  <= active_count_ff;
                     hi_ff   <= active_count_ff;
                  end
               end
            end
            S_SEARCH: begin
               mid_ff <= mid;
            end
            S_CMP: begin
               // descending order: larger stored address lies before the key
               if (rd_data_ff[ENTRY_W-1:PERM_W] > key_ff) begin
                  lo_ff <= mid_ff + POS_W'(1);
               end else begin
                  hi_ff <= mid_ff;
               end
            end
            S_PROBE: begin
               pos_ok_ff <= (lo_ff < cnt_ff);
            end
            S_DECIDE: begin
               idx_ff <= shadow_count_ff;
               if (!is_load_ff) begin
                  res_count_ff <= active_count_ff;
                  if (found && ((rd_data_ff[PERM_W-1:0] & acc_ff) != '0)) begin
                     res_status_ff <= STATUS_ALLOWED;
                  end else begin
                     res_status_ff <= STATUS_DENIED;
                  end
               end else begin
                  res_count_ff  <= shadow_count_ff;
                  res_status_ff <= (!found && shadow_full) ? STATUS_FULL : STATUS_LOADED;
               end
            end
            S_SHIFT_RD: begin
               if (!shift_more) begin
                  shadow_count_ff <= shadow_count_ff + POS_W'(1);
                  res_count_ff    <= shadow_count_ff + POS_W'(1);
                  res_status_ff   <= STATUS_LOADED;
               end
            end
            S_SHIFT_WR: begin
               idx_ff <= idx_ff - POS_W'(1);
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_status_ff      <= res_status_ff;
                  rsp_entry_count_ff <= to_count(res_count_ff);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

`ifndef NO_ASSERTIONS
   // bank counts never pass the bank size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (active_count_ff <= POS_W'(TABLE_DEPTH)) && (shadow_count_ff <= POS_W'(TABLE_DEPTH)))
      else $error("bank count beyond table depth");

   // search interval stays ordered and inside the searched count
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH || state_ff == S_CMP) |-> (lo_ff <= hi_ff) && (hi_ff <= cnt_ff))
      else $error("search bounds out of order");

   // every shift write lands inside the shadow bank, past the insertion point
   a_shift_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_WR) |-> (idx_ff > lo_ff) && (idx_ff <= shadow_count_ff)
                                   && (shadow_count_ff < POS_W'(TABLE_DEPTH)))
      else $error("shift outside shadow bank");

   // a result is only loaded when the output register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_status_ff)
                                       && $stable(rsp_entry_count_ff))
      else $error("pending result overwritten");
`endif

endmodule
